FILE: hdl/cpt_pkg.sv
// shared types, constants and helpers of the cascaded prescaled timer group
package cpt_pkg;

    localparam int NUM_TIMERS  = 4;
    localparam int TICK_WIDTH  = 12;
    localparam int TIMER_IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam int MODE_W  = 2;
    localparam int SEL_W   = 2;
    localparam int OFF_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int TICK_W  = 12;
    localparam int IRQ_W   = 4;
    localparam int VALUE_W = 16;
    localparam int SHIFT_W = 4;

    // internal counter width; the counter counts raw tick cycles, before prescaling
    localparam int CNT_W  = 28;
    localparam int STEP_W = $clog2(CNT_W);

    localparam logic [SHIFT_W-1:0] MAX_SHIFT = 4'd10;

    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    localparam logic [OFF_W-1:0] OFF_RELOAD_LO = 2'd0;
    localparam logic [OFF_W-1:0] OFF_RELOAD_HI = 2'd1;
    localparam logic [OFF_W-1:0] OFF_CTRL_LO   = 2'd2;
    localparam logic [OFF_W-1:0] OFF_CTRL_HI   = 2'd3;

    localparam int CTL_START_BIT   = 7;
    localparam int CTL_IRQ_BIT     = 6;
    localparam int CTL_CASCADE_BIT = 2;

    localparam logic [TICK_W-1:0] TICK_MASK = TICK_W'((33'd1 << TICK_WIDTH) - 33'd1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_CHECK,
        ST_DIV,
        ST_FIN,
        ST_CASC,
        ST_DONE
    } cpt_state_t;

    function automatic logic [SHIFT_W-1:0] prescale_shift_of(input logic [1:0] sel);
        logic [SHIFT_W-1:0] sh;
        case (sel)
            2'd0:    sh = 4'd0;
            2'd1:    sh = 4'd6;
            2'd2:    sh = 4'd8;
            default: sh = 4'd10;
        endcase
        return sh;
    endfunction

endpackage

FILE: hdl/cpt_cmd_if.sv
// command channel: one register access or time tick per transaction
interface cpt_cmd_if import cpt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SEL_W-1:0]  timer_select;
    logic [OFF_W-1:0]  byte_offset;
    logic [BYTE_W-1:0] write_data;
    logic [TICK_W-1:0] tick_cycles;

    modport source (output valid, mode, timer_select, byte_offset, write_data, tick_cycles,
                    input ready);
    modport sink (input valid, mode, timer_select, byte_offset, write_data, tick_cycles,
                  output ready);
endinterface

FILE: hdl/cpt_rsp_if.sv
// response channel: one result per command transaction
interface cpt_rsp_if import cpt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic [IRQ_W-1:0]  irq_pulses;
    logic              run_flag;

    modport source (output valid, read_data, irq_pulses, run_flag, input ready);
    modport sink (input valid, read_data, irq_pulses, run_flag, output ready);
endinterface

FILE: hdl/cascaded_prescaled_timer_group.sv
// top level of the cascaded prescaled timer group
//
// a group of reload timers reached through byte registers on the cmd channel;
// each cmd transaction gives exactly one rsp transaction, in order
// - mode write: stores a byte; a rising start bit in control low byte
//   loads the counter from the reload value and latches prescale, cascade
//   and irq enable
// - mode read: returns counter bytes (shifted down by prescale) or control
// - mode tick: adds tick_cycles to every free-running timer, timer 0 first;
//   overflows reload modulo the span and feed the next cascaded timer
// register accesses answer in the cycle after acceptance; a tick visits each timer
// in turn: a stopped timer is passed over in ST_ADD, a free-running one is added
// to and checked for overflow (ST_ADD, ST_CHECK); each overflow runs the bit-serial
// restoring divider (one quotient bit per cycle) that splits the overrun into wrap
// count and remainder, then ST_FIN reloads, ST_CASC hands the count on and ST_CHECK
// checks a cascaded target (the last timer has no hand-off); ST_DONE posts the result
// the block works on one transaction at a time; cmd is ready in idle while
// the rsp register is empty or being drained in the same cycle
// a stalled rsp receiver holds the result and blocks the next command
// reset clears all timers, the sequencer and the rsp valid flag; datapath registers are not reset
module cascaded_prescaled_timer_group import cpt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    cpt_cmd_if.sink   cmd,
    cpt_rsp_if.source rsp
);

    // per-timer state
    logic [VALUE_W-1:0] reload_reg [NUM_TIMERS];
    logic [VALUE_W-1:0] reload_next [NUM_TIMERS];
    logic [VALUE_W-1:0] ctrl_reg [NUM_TIMERS];
    logic [VALUE_W-1:0] ctrl_next [NUM_TIMERS];
    logic [CNT_W-1:0]   cnt_reg [NUM_TIMERS];
    logic [CNT_W-1:0]   cnt_next [NUM_TIMERS];
    logic [SHIFT_W-1:0] shift_reg [NUM_TIMERS];
    logic [SHIFT_W-1:0] shift_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] run_reg, run_next;
    logic [NUM_TIMERS-1:0] casc_reg, casc_next;
    logic [NUM_TIMERS-1:0] irqen_reg, irqen_next;
    logic [NUM_TIMERS-1:0] free_reg, free_next;

    // tick sequencer and divider
    cpt_state_t state_reg, state_next;
    logic [TIMER_IDX_W-1:0] li_reg, li_next;   // loop position over timers
    logic [TIMER_IDX_W-1:0] ci_reg, ci_next;   // timer being worked on
    logic [TICK_W-1:0]      cyc_reg, cyc_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]       quo_reg, quo_next;  // dividend in, quotient out, then wrap count
    logic [CNT_W-1:0]       dvs_reg, dvs_next;
    logic [CNT_W-1:0]       base_reg, base_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [IRQ_W-1:0]       pulse_reg, pulse_next;

    // response register
    logic              ov_reg, ov_next;
    logic [BYTE_W-1:0] rd_reg, rd_next;
    logic [IRQ_W-1:0]  irq_reg, irq_next;
    logic              rf_reg, rf_next;

    logic                   slot_free;
    logic                   accept;
    logic                   sel_ok;
    logic [TIMER_IDX_W-1:0] idx;
    logic [CNT_W-1:0]       scaled_view;
    logic [SHIFT_W-1:0]     sh_c;
    logic [CNT_W-1:0]       span;
    logic [CNT_W:0]         trial;
    logic                   last_timer;
    logic                   start_bit;
    logic                   was_running;
    logic [VALUE_W-1:0]     ctrl_new;

    assign slot_free = !ov_reg || rsp.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && slot_free;
    assign accept    = cmd.valid && cmd.ready;

    assign sel_ok = (32'(cmd.timer_select) < NUM_TIMERS);
    // one timer is looked at per cycle: the addressed one in idle, else the working one
    assign idx    = (state_reg == ST_IDLE) ? TIMER_IDX_W'(cmd.timer_select) : ci_reg;

    assign scaled_view = cnt_reg[idx] >> shift_reg[idx];
    assign sh_c        = (shift_reg[idx] > MAX_SHIFT) ? MAX_SHIFT : shift_reg[idx];
    assign span        = CNT_W'(1) << ({1'b0, sh_c} + 5'd16);
    assign trial       = {rem_reg, quo_reg[CNT_W-1]};
    assign last_timer  = (32'(ci_reg) == NUM_TIMERS - 1);

    assign start_bit   = cmd.write_data[CTL_START_BIT];
    assign was_running = run_reg[idx] && start_bit;
    assign ctrl_new    = {ctrl_reg[idx][VALUE_W-1:BYTE_W], cmd.write_data};

    assign rsp.valid      = ov_reg;
    assign rsp.read_data  = rd_reg;
    assign rsp.irq_pulses = irq_reg;
    assign rsp.run_flag   = rf_reg;

    always_comb
    begin
        reload_next = reload_reg;
        ctrl_next   = ctrl_reg;
        cnt_next    = cnt_reg;
        shift_next  = shift_reg;
        run_next    = run_reg;
        casc_next   = casc_reg;
        irqen_next  = irqen_reg;
        free_next   = free_reg;
        state_next  = state_reg;
        li_next     = li_reg;
        ci_next     = ci_reg;
        cyc_next    = cyc_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        base_next   = base_reg;
        step_next   = step_reg;
        pulse_next  = pulse_reg;
        ov_next     = ov_reg && !rsp.ready;
        rd_next     = rd_reg;
        irq_next    = irq_reg;
        rf_next     = rf_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.mode == MODE_TICK)
                    begin
                        pulse_next = '0;
                        cyc_next   = cmd.tick_cycles & TICK_MASK;
                        li_next    = '0;
                        ci_next    = '0;
                        state_next = ST_ADD;
                    end
                    else
                    begin
                        rd_next = '0;
                        if (cmd.mode == MODE_WRITE && sel_ok)
                        begin
                            case (cmd.byte_offset)
                                OFF_RELOAD_LO: reload_next[idx][7:0]  = cmd.write_data;
                                OFF_RELOAD_HI: reload_next[idx][15:8] = cmd.write_data;
                                OFF_CTRL_HI:   ctrl_next[idx][15:8]   = cmd.write_data;
                                default:
                                begin
                                    ctrl_next[idx] = ctrl_new;
                                    run_next[idx]  = was_running;
                                    free_next[idx] = start_bit;
                                    if (!was_running && start_bit)
                                    begin
                                        run_next[idx]   = 1'b1;
                                        irqen_next[idx] = ctrl_new[CTL_IRQ_BIT];
                                        if (idx != '0 && ctrl_new[CTL_CASCADE_BIT])
                                        begin
                                            casc_next[idx]  = 1'b1;
                                            shift_next[idx] = '0;
                                            free_next[idx]  = 1'b0;
                                            cnt_next[idx]   = CNT_W'(reload_reg[idx]);
                                        end
                                        else
                                        begin
                                            casc_next[idx]  = 1'b0;
                                            shift_next[idx] = prescale_shift_of(ctrl_new[1:0]);
                                            cnt_next[idx]   = CNT_W'(reload_reg[idx])
                                                << prescale_shift_of(ctrl_new[1:0]);
                                        end
                                    end
                                end
                            endcase
                        end
                        else if (cmd.mode == MODE_READ && sel_ok)
                        begin
                            case (cmd.byte_offset)
                                OFF_RELOAD_LO: rd_next = scaled_view[7:0];
                                OFF_RELOAD_HI: rd_next = scaled_view[15:8];
                                OFF_CTRL_LO:   rd_next = ctrl_reg[idx][7:0];
                                default:       rd_next = ctrl_reg[idx][15:8];
                            endcase
                        end
                        ov_next  = 1'b1;
                        irq_next = '0;
                        rf_next  = |free_next;
                    end
                end
            end

            ST_ADD:
            begin
                if (free_reg[ci_reg])
                begin
                    cnt_next[ci_reg] = cnt_reg[ci_reg] + CNT_W'(cyc_reg);
                    state_next       = ST_CHECK;
                end
                else if (32'(li_reg) == NUM_TIMERS - 1)
                    state_next = ST_DONE;
                else
                begin
                    li_next    = li_reg + 1'b1;
                    ci_next    = li_reg + 1'b1;
                    state_next = ST_ADD;
                end
            end

            ST_CHECK:
            begin
                if (cnt_reg[ci_reg] >= span)
                begin
                    if (irqen_reg[ci_reg])
                        pulse_next[ci_reg] = 1'b1;
                    base_next  = CNT_W'(reload_reg[ci_reg]) << sh_c;
                    dvs_next   = span - (CNT_W'(reload_reg[ci_reg]) << sh_c);
                    quo_next   = cnt_reg[ci_reg] - span;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
                else if (32'(li_reg) == NUM_TIMERS - 1)
                    state_next = ST_DONE;
                else
                begin
                    li_next    = li_reg + 1'b1;
                    ci_next    = li_reg + 1'b1;
                    state_next = ST_ADD;
                end
            end

            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_next = CNT_W'(trial - {1'b0, dvs_reg});
                    quo_next = {quo_reg[CNT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[CNT_W-1:0];
                    quo_next = {quo_reg[CNT_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CNT_W - 1))
                    state_next = ST_FIN;
            end

            ST_FIN:
            begin
                cnt_next[ci_reg] = rem_reg + base_reg;
                quo_next         = quo_reg + CNT_W'(1);   // wrap count
                if (last_timer)
                begin
                    // no cascade target beyond the last timer
                    if (32'(li_reg) == NUM_TIMERS - 1)
                        state_next = ST_DONE;
                    else
                    begin
                        li_next    = li_reg + 1'b1;
                        ci_next    = li_reg + 1'b1;
                        state_next = ST_ADD;
                    end
                end
                else
                begin
                    ci_next    = ci_reg + 1'b1;
                    state_next = ST_CASC;
                end
            end

            ST_CASC:
            begin
                if (run_reg[ci_reg] && casc_reg[ci_reg])
                begin
                    cnt_next[ci_reg] = cnt_reg[ci_reg] + quo_reg;
                    state_next       = ST_CHECK;
                end
                else if (32'(li_reg) == NUM_TIMERS - 1)
                    state_next = ST_DONE;
                else
                begin
                    li_next    = li_reg + 1'b1;
                    ci_next    = li_reg + 1'b1;
                    state_next = ST_ADD;
                end
            end

            ST_DONE:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    rd_next    = '0;
                    irq_next   = pulse_reg;
                    rf_next    = |free_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                reload_reg[i] <= '0;
                ctrl_reg[i]   <= '0;
                cnt_reg[i]    <= '0;
                shift_reg[i]  <= '0;
            end
            run_reg   <= '0;
            casc_reg  <= '0;
            irqen_reg <= '0;
            free_reg  <= '0;
            state_reg <= ST_IDLE;
            li_reg    <= '0;
            ci_reg    <= '0;
            step_reg  <= '0;
            pulse_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            reload_reg <= reload_next;
            ctrl_reg   <= ctrl_next;
            cnt_reg    <= cnt_next;
            shift_reg  <= shift_next;
            run_reg    <= run_next;
            casc_reg   <= casc_next;
            irqen_reg  <= irqen_next;
            free_reg   <= free_next;
            state_reg  <= state_next;
            li_reg     <= li_next;
            ci_reg     <= ci_next;
            step_reg   <= step_next;
            pulse_reg  <= pulse_next;
            ov_reg     <= ov_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cyc_reg  <= cyc_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        base_reg <= base_next;
        rd_reg   <= rd_next;
        irq_reg  <= irq_next;
        rf_reg   <= rf_next;
    end

    // the divider never runs past the counter width
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> 32'(step_reg) < CNT_W)
        else $error("divider step count out of range");

    // a tick transaction starts the timer sweep at timer 0
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.mode == MODE_TICK |=> state_reg == ST_ADD && ci_reg == '0)
        else $error("tick did not start the sweep");

    // no command is taken while a tick is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !cmd.ready)
        else $error("command accepted while busy");

    // a finished tick posts its result only into a free response slot
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && slot_free |=> ov_reg && state_reg == ST_IDLE)
        else $error("tick result not posted");

endmodule
